/* src/cmi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Costmap inflation 3x3 package
// Item types, register indexes and the window helpers shared by the block.
// ----------------------------------------------------------------------------
package cmi3_pkg;

  localparam int CfgIdxW    = 3;
  localparam int MapWidthW  = 10;
  localparam int MapHeightW = 13;
  localparam int RowCountW  = 12;
  localparam int MaxHeight  = 4096;

  localparam logic [CfgIdxW-1:0] CFG_MAP_WIDTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAP_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LETHAL_VALUE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_COST  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_COST    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CORNER_COST  = 3'd5;

  localparam logic ACTION_CELL  = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  // Window bit index is row * 3 + col, row 0 on top, col 0 on the left.
  localparam logic [8:0] CornerMask = 9'h145;
  localparam logic [8:0] EdgeMask   = 9'h0AA;
  localparam logic [8:0] CenterMask = 9'h010;
  localparam logic [8:0] KeepMask   = 9'h0DB;

  typedef struct packed {
    logic       action;
    logic [7:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cost;
    logic       last_of_frame;
  } out_item_t;

  // Shift the window one column left and insert a new right column.
  function automatic logic [8:0] win_shift(logic [8:0] win, logic top, logic mid,
                                           logic bot);
    logic [8:0] w;
    w    = (win >> 1) & KeepMask;
    w[2] = top;
    w[5] = mid;
    w[8] = bot;
    return w;
  endfunction

  function automatic logic [7:0] win_cost(logic [8:0] win, logic [7:0] center_cost,
                                          logic [7:0] edge_cost, logic [7:0] corner_cost);
    logic [7:0] best;
    best = 8'd0;
    if (((win & CornerMask) != 9'd0) && (corner_cost > best)) best = corner_cost;
    if (((win & EdgeMask) != 9'd0) && (edge_cost > best)) best = edge_cost;
    if (((win & CenterMask) != 9'd0) && (center_cost > best)) best = center_cost;
    return best;
  endfunction

endpackage

/* src/costmap_inflation_3x3_top.sv */
`timescale 1ns / 1ps
// A cell's cost is formed from the stage register once the item that completes
// its neighborhood (one row and one column later) is accepted. Throughput: one
// item per cycle unless stalled; an end-of-row item yields two results, and
// the output port takes one per cycle, so a four-entry result queue stalls input.
// Reset clears counters, window, stage and queue; the line buffers keep no reset.
// ----------------------------------------------------------------------------
// Costmap obstacle inflation, 3x3 kernel
// Streams raster cells, keeps obstacle flags of two rows in a line buffer
// memory and slides a 3x3 flag window to produce the inflated cost per cell.
// ----------------------------------------------------------------------------
module costmap_inflation_3x3_top
  import cmi3_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_addr_i,
  input  logic [MapHeightW-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > MapWidthW) ? CW + 1 : MapWidthW;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;

  // Configuration registers.
  logic [MapWidthW-1:0]  map_width_q;
  logic [MapHeightW-1:0] map_height_q;
  logic [7:0] lethal_value_q, center_cost_q, edge_cost_q, corner_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q    <= 10'd384;
      map_height_q   <= 13'd384;
      lethal_value_q <= 8'd254;
      center_cost_q  <= 8'd254;
      edge_cost_q    <= 8'd80;
      corner_cost_q  <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MAP_WIDTH:    map_width_q    <= cfg_wdata_i[MapWidthW-1:0];
        CFG_MAP_HEIGHT:   map_height_q   <= cfg_wdata_i;
        CFG_LETHAL_VALUE: lethal_value_q <= cfg_wdata_i[7:0];
        CFG_CENTER_COST:  center_cost_q  <= cfg_wdata_i[7:0];
        CFG_EDGE_COST:    edge_cost_q    <= cfg_wdata_i[7:0];
        CFG_CORNER_COST:  corner_cost_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective map size, clamped to the supported range.
  logic [WW-1:0]         w_eff;
  logic [MapHeightW-1:0] h_eff;

  always_comb begin
    w_eff = WW'(map_width_q);
    if (map_width_q == '0) w_eff = WW'(1);
    else if (WW'(map_width_q) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    h_eff = map_height_q;
    if (map_height_q == '0) h_eff = MapHeightW'(1);
    else if (map_height_q > MapHeightW'(MaxHeight)) h_eff = MapHeightW'(MaxHeight);
  end

  // Position counters. The column counter also counts flush items.
  logic [CW-1:0]        col_q, col_d;
  logic [RowCountW-1:0] row_q, row_d;
  logic                 draining_q, draining_d;

  // Stage register between acceptance and the window logic.
  logic          a_valid_q, a_valid_d;
  logic          a_flush_q, a_cur_q, a_first_q, a_top_ok_q, a_mid_ok_q, a_end_row_q;
  logic [CW-1:0] a_ci_q;
  logic          a_adv;

  // Line buffer entry: bit 1 is the flag two rows above, bit 0 the row above.
  logic [1:0] lb_mem [MAX_WIDTH];
  logic [1:0] rd_q, fwd_val_q, lb_rd, lb_wr;
  logic       fwd_q;

  // Result queue.
  out_item_t        q_mem [QDepth];
  logic [QPtrW-1:0] q_wr_q, q_rd_q;
  logic [QCntW-1:0] q_cnt_q, q_cnt_d;
  logic             q_pop;

  logic [8:0] win_q, win_d, win0, win1, win2;
  logic       res1_v, res2_v;
  out_item_t  res1, res2;

  logic accept, take, is_cell, end_row, cur;

  assign accept  = in_valid_i && !in_stall_o;
  assign is_cell = (in_item_i.action == ACTION_CELL);
  assign take    = accept && (is_cell ? !draining_q : draining_q);
  assign end_row = ((WW'(col_q) + WW'(1)) >= w_eff);
  assign cur     = is_cell && (in_item_i.cell_value == lethal_value_q);

  // The stage moves on when the queue has room for two results.
  assign a_adv      = a_valid_q && (q_cnt_q <= QCntW'(QDepth - 2));
  assign in_stall_o = a_valid_q && !a_adv;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    draining_d = draining_q;
    if (take) begin
      if (is_cell) begin
        if (end_row) begin
          col_d = '0;
          if ((MapHeightW'(row_q) + MapHeightW'(1)) >= h_eff) begin
            draining_d = 1'b1;
            row_d      = '0;
          end else begin
            row_d = row_q + RowCountW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end else begin
        if (end_row) begin
          col_d      = '0;
          row_d      = '0;
          draining_d = 1'b0;
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (take) a_valid_d = 1'b1;
    else if (a_adv) a_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      draining_q <= 1'b0;
      a_valid_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      draining_q <= draining_d;
      a_valid_q  <= a_valid_d;
      if (take) begin
        fwd_q <= a_adv && !a_flush_q && (a_ci_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_flush_q   <= !is_cell;
      a_cur_q     <= cur;
      a_ci_q      <= col_q;
      a_first_q   <= (col_q == '0);
      a_mid_ok_q  <= is_cell ? (row_q != '0) : 1'b1;
      a_top_ok_q  <= is_cell ? (row_q >= RowCountW'(2)) : (h_eff >= MapHeightW'(2));
      a_end_row_q <= end_row;
      fwd_val_q   <= lb_wr;
    end
  end

  // A write by the item ahead to the same column is forwarded around the memory.
  assign lb_rd = fwd_q ? fwd_val_q : rd_q;
  assign lb_wr = {lb_rd[0], a_cur_q};

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q <= lb_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && !a_flush_q) begin
      lb_mem[a_ci_q] <= lb_wr;
    end
  end

  // Window and results for the item in the stage register.
  always_comb begin
    win0   = a_first_q ? 9'd0 : win_q;
    win1   = win_shift(win0, lb_rd[1] && a_top_ok_q, lb_rd[0] && a_mid_ok_q, a_cur_q);
    win2   = win_shift(win1, 1'b0, 1'b0, 1'b0);
    res1_v = a_adv && a_mid_ok_q && !a_first_q;
    res2_v = a_adv && a_mid_ok_q && a_end_row_q;
    res1.cost          = win_cost(win1, center_cost_q, edge_cost_q, corner_cost_q);
    res1.last_of_frame = 1'b0;
    res2.cost          = win_cost(win2, center_cost_q, edge_cost_q, corner_cost_q);
    res2.last_of_frame = a_flush_q;
    win_d = win_q;
    if (a_adv) begin
      if (a_flush_q && a_end_row_q) win_d = 9'd0;
      else if (a_end_row_q) win_d = win2;
      else win_d = win1;
    end
  end

  assign q_pop = out_valid_o && !out_stall_i;

  always_comb begin
    q_cnt_d = q_cnt_q + QCntW'(res1_v) + QCntW'(res2_v);
    if (q_pop) q_cnt_d = q_cnt_d - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      win_q   <= win_d;
      q_wr_q  <= q_wr_q + QPtrW'(res1_v) + QPtrW'(res2_v);
      if (q_pop) q_rd_q <= q_rd_q + QPtrW'(1);
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res1_v) q_mem[q_wr_q] <= res1;
    if (res2_v) q_mem[q_wr_q + QPtrW'(res1_v)] <= res2;
  end

  assign out_valid_o = (q_cnt_q != '0);
  assign out_item_o  = q_mem[q_rd_q];

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // The final flush item of a frame leaves a cleared window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_flush_q && a_end_row_q) |=> (win_q == 9'd0))
    else $error("window not cleared at end of frame");

  // Forwarding is only armed when the item ahead wrote the line buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(fwd_q)) |-> $past(a_adv && !a_flush_q))
    else $error("line buffer forward without a write");

endmodule
